@@ hdl/pssg_pkg.sv @@
package pssg_pkg;

   // configuration port
   localparam int CFG_W       = 10;
   localparam int CFG_INDEX_W = 3;
   localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_SPAN = 3'd0;
   localparam logic [CFG_INDEX_W-1:0] REG_START_WIDTH = 3'd1;
   localparam logic [CFG_INDEX_W-1:0] REG_END_WIDTH   = 3'd2;
   localparam logic [CFG_INDEX_W-1:0] REG_VIEW_WIDTH  = 3'd3;
   localparam logic [CFG_INDEX_W-1:0] REG_VIEW_HEIGHT = 3'd4;

   // payload
   localparam int COORD_W = 9;
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // line width: 21 integer bits plus 16 fraction bits
   localparam int WIDTH_INT_W = 21;
   localparam int WIDTH_W     = WIDTH_INT_W + 16;
   localparam int LINE_W      = 10;
   localparam int XSTEP_W     = 32;

   // controller to datapath commands
   typedef struct packed {
      logic load_start;
      logic step;
      logic mul;
      logic sum;
      logic div_start;
      logic div_sel;
      logic latch_w;
      logic fin;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic eol;
      logic eof;
      logic div_done;
   } status_type;

endpackage

@@ hdl/pssg_if.sv @@
interface pssg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [pssg_pkg::COORD_W-1:0]  scroll_x;
   logic [pssg_pkg::COORD_W-1:0]  scroll_y;

   modport source (output valid, func, scroll_x, scroll_y, input ready);
   modport sink   (input valid, func, scroll_x, scroll_y, output ready);
endinterface

interface pssg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pssg_pkg::COORD_W-1:0]  source_row;
   logic [pssg_pkg::COORD_W-1:0]  source_col_left;
   logic [pssg_pkg::COORD_W-1:0]  source_col_right;
   logic [pssg_pkg::COORD_W-1:0]  dest_row;
   logic [pssg_pkg::COORD_W-1:0]  dest_col_left;
   logic [pssg_pkg::COORD_W-1:0]  dest_col_right;
   logic                          end_of_line;
   logic                          end_of_frame;

   modport source (output valid, source_row, source_col_left, source_col_right, dest_row,
                   dest_col_left, dest_col_right, end_of_line, end_of_frame, input ready);
   modport sink   (input valid, source_row, source_col_left, source_col_right, dest_row,
                   dest_col_left, dest_col_right, end_of_line, end_of_frame, output ready);
endinterface

@@ hdl/pssg_divider.sv @@
// Restoring divider, one quotient bit per cycle, MSB first.
module pssg_divider #(
   parameter int DVD_W = 52,
   parameter int DSR_W = 37,
   parameter int QUO_W = 89
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient,
   output logic             done
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   shifted;
   logic [DSR_W:0]   diff;
   logic             qbit;

   // trial subtract
   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      qbit    = (shifted >= {1'b0, dsr_ff});
   end

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = qbit ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

@@ hdl/pssg_datapath.sv @@
// Registers, line setup arithmetic and result payload.
module pssg_datapath #(
   parameter int SOURCE_SIZE   = 512,
   parameter int FRACTION_BITS = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [pssg_pkg::CFG_INDEX_W-1:0]   csr_index,
   input  logic [pssg_pkg::CFG_W-1:0]         csr_write_data,
   input  logic [pssg_pkg::COORD_W-1:0]       scroll_x,
   input  logic [pssg_pkg::COORD_W-1:0]       scroll_y,
   input  pssg_pkg::cmd_type                  cmd,
   output pssg_pkg::status_type               status,
   output logic [pssg_pkg::COORD_W-1:0]       source_row,
   output logic [pssg_pkg::COORD_W-1:0]       source_col_left,
   output logic [pssg_pkg::COORD_W-1:0]       source_col_right,
   output logic [pssg_pkg::COORD_W-1:0]       dest_row,
   output logic [pssg_pkg::COORD_W-1:0]       dest_col_left,
   output logic [pssg_pkg::COORD_W-1:0]       dest_col_right,
   output logic                               end_of_line,
   output logic                               end_of_frame
);
   localparam int SB    = $clog2(SOURCE_SIZE);
   localparam int FB    = FRACTION_BITS;
   localparam int CW    = SB + FB;
   localparam int YW    = SB + FB + 16;
   localparam int WW    = pssg_pkg::WIDTH_W;
   localparam int DW    = pssg_pkg::CFG_W + FB + 32;
   localparam int QW    = YW + WW;
   localparam int CFGW  = pssg_pkg::CFG_W;
   localparam int CO    = pssg_pkg::COORD_W;
   localparam int LW    = pssg_pkg::LINE_W;
   localparam int XW    = pssg_pkg::XSTEP_W;
   localparam logic [XW-1:0] HALF    = XW'((64'd1 << (FB - 1)) - 64'd1);
   localparam logic [YW-1:0] Y_RESET = YW'(((64'd1 << (FB - 1)) - 64'd1) << 16);
   localparam logic [YW-1:0] YMASK   = '1;

   // configuration registers
   logic [CFGW-1:0] span_ff, start_w_ff, end_w_ff, view_w_ff, view_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff    <= CFGW'(512);
         start_w_ff <= CFGW'(96);
         end_w_ff   <= CFGW'(480);
         view_w_ff  <= CFGW'(256);
         view_h_ff  <= CFGW'(224);
      end else if (csr_write_enable) begin
         case (csr_index)
            pssg_pkg::REG_SOURCE_SPAN: span_ff    <= csr_write_data;
            pssg_pkg::REG_START_WIDTH: start_w_ff <= csr_write_data;
            pssg_pkg::REG_END_WIDTH:   end_w_ff   <= csr_write_data;
            pssg_pkg::REG_VIEW_WIDTH:  view_w_ff  <= csr_write_data;
            pssg_pkg::REG_VIEW_HEIGHT: view_h_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // scan state
   logic [SB-1:0]    xc_ff, row_origin_ff, cur_row_ff;
   logic [LW-1:0]    line_ff;
   logic [CO-1:0]    pair_ff, pair_end_ff;
   logic [XW-1:0]    x_accum_ff, x_step_ff;
   logic [YW-1:0]    y_accum_ff;
   logic [19:0]      prod_a_ff;
   logic [20:0]      prod_b_ff;
   logic [21:0]      m_ff;
   logic [WW-1:0]    w_ff;

   // combinational helpers
   logic [CFGW-1:0]  vh;
   logic [CFGW-1:0]  span_m1;
   logic [YW-1:0]    step_val;
   logic [63:0]      xs_wide;
   logic [WW-16-1:0] w_int;
   logic [WW-16-1:0] xend_cl;
   logic [CO-1:0]    xend;
   logic [CO-1:0]    half;
   logic [CW-1:0]    x_center;
   logic [CW-1:0]    xa_c;
   logic [CW-1:0]    col_l, col_r;
   logic [LW:0]      line_p1;
   logic             eol, eof;
   logic [DW-1:0]    div_dividend;
   logic [WW-1:0]    div_divisor;
   logic [QW-1:0]    quotient;
   logic             div_done;

   always_comb begin
      vh       = (view_h_ff == '0) ? CFGW'(1) : view_h_ff;
      span_m1  = (span_ff == '0) ? '0 : span_ff - 1'b1;
      step_val = (quotient[QW-1:YW] != '0) ? YMASK : quotient[YW-1:0];
      xs_wide  = 64'(step_val >> 16);
      w_int    = w_ff[WW-1:16];
      xend_cl  = (w_int > (WW-16)'(view_w_ff)) ? (WW-16)'(view_w_ff) : w_int;
      xend     = CO'(xend_cl >> 1);
      half     = CO'(view_w_ff >> 1);
      x_center = {xc_ff, {FB{1'b0}}};
      xa_c     = CW'({{CW{1'b0}}, x_accum_ff});
      col_l    = x_center - xa_c;
      col_r    = x_center + xa_c;
      line_p1  = {1'b0, line_ff} + 1'b1;
      eol      = (pair_ff == pair_end_ff);
      eof      = eol && (line_p1 >= (LW+1)'(vh));
      if (cmd.div_sel) begin
         div_dividend = DW'({span_m1, {(FB + 32){1'b0}}});
         div_divisor  = w_ff;
      end else begin
         div_dividend = DW'({m_ff[20:0], 16'b0});
         div_divisor  = WW'(vh);
      end
   end

   pssg_divider #(.DVD_W(DW), .DSR_W(WW), .QUO_W(QW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   // state updates driven by the controller
   always_ff @(posedge clock) begin
      if (reset) begin
         xc_ff         <= '0;
         row_origin_ff <= '0;
         cur_row_ff    <= '0;
         line_ff       <= '0;
         pair_ff       <= '0;
         pair_end_ff   <= '0;
         x_accum_ff    <= HALF;
         x_step_ff     <= '0;
         y_accum_ff    <= Y_RESET;
      end else begin
         if (cmd.load_start) begin
            xc_ff         <= SB'(SB'(scroll_x) + SB'(span_ff >> 1));
            row_origin_ff <= SB'(scroll_y);
            y_accum_ff    <= Y_RESET;
            line_ff       <= '0;
         end
         if (cmd.mul) begin
            cur_row_ff <= row_origin_ff + y_accum_ff[YW-1 -: SB];
         end
         if (cmd.fin) begin
            x_step_ff   <= (xs_wide[63:32] != '0) ? '1 : xs_wide[31:0];
            y_accum_ff  <= y_accum_ff + step_val;
            x_accum_ff  <= HALF;
            pair_ff     <= '0;
            pair_end_ff <= (xend == '0) ? '0 : xend - 1'b1;
         end
         if (cmd.step) begin
            x_accum_ff <= x_accum_ff + x_step_ff;
            if (eol) begin
               line_ff <= line_ff + 1'b1;
            end else begin
               pair_ff <= pair_ff + 1'b1;
            end
         end
      end
   end

   // line width arithmetic
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_a_ff <= start_w_ff * vh;
         prod_b_ff <= 21'($signed({1'b0, end_w_ff}) - $signed({1'b0, start_w_ff}))
                      * $signed({1'b0, line_ff});
      end
      if (cmd.sum) begin
         m_ff <= {2'b0, prod_a_ff} + {prod_b_ff[20], prod_b_ff};
      end
      if (cmd.latch_w) begin
         w_ff <= ($signed(m_ff) > 0) ? quotient[WW-1:0] : WW'(1);
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         source_row       <= CO'(cur_row_ff);
         source_col_left  <= CO'(col_l[CW-1:FB]);
         source_col_right <= CO'(col_r[CW-1:FB]);
         dest_row         <= CO'(line_ff);
         dest_col_left    <= half - pair_ff - 1'b1;
         dest_col_right   <= half + pair_ff;
         end_of_line      <= eol;
         end_of_frame     <= eof;
      end
   end

   assign status.eol      = eol;
   assign status.eof      = eof;
   assign status.div_done = div_done;

endmodule

@@ hdl/pssg_ctrl.sv @@
// Frame and line sequencer with result valid flag.
module pssg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pssg_pkg::status_type  status,
   output pssg_pkg::cmd_type     cmd
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RUN   = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_SUM   = 4'd3;
   localparam logic [3:0] ST_DIV1S = 4'd4;
   localparam logic [3:0] ST_DIV1  = 4'd5;
   localparam logic [3:0] ST_DIV2S = 4'd6;
   localparam logic [3:0] ST_DIV2  = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE || state_ff == ST_RUN) &&
                      (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE, ST_RUN: begin
            if (accept) begin
               if (req_func == pssg_pkg::FUNC_START) begin
                  cmd.load_start = 1'b1;
                  state_in       = ST_MUL;
               end else if (state_ff == ST_RUN) begin
                  cmd.step     = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (status.eof) begin
                     state_in = ST_IDLE;
                  end else if (status.eol) begin
                     state_in = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DIV1S;
         end
         ST_DIV1S: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV1;
         end
         ST_DIV1: begin
            if (status.div_done) begin
               cmd.latch_w = 1'b1;
               state_in    = ST_DIV2S;
            end
         end
         ST_DIV2S: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_sel = 1'b1;
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.div_sel = 1'b1;
            cmd.fin     = 1'b1;
            state_in    = ST_RUN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // no transaction taken while a line is being set up
   a_no_accept_in_setup: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_IDLE || state_ff == ST_RUN) |-> !req_ready)
      else $error("input accepted during line setup");

   // divider finishes only while it is awaited
   a_div_done_awaited: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("unexpected divider completion");

   // setup always ends in the running state
   a_fin_to_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |=> state_ff == ST_RUN)
      else $error("setup did not return to run");

endmodule

@@ hdl/perspective_slant_scan_generator_unit.sv @@
// Perspective floor scan address generator. A transaction with func 0 latches the
// scroll position, opens a frame and returns nothing; each transaction with func 1
// returns one mirrored pixel pair of source and destination addresses, flagged at
// line and frame end. A step is taken once the previous pair is accepted. At
// every line start (after a start transaction or the last pair of a line) the
// block sets up the line in multiply, sum, divide and finish states; the serial
// divider forms the line width and source step one quotient bit per cycle; no
// transaction is taken meanwhile. Step transactions outside a frame are consumed
// with no result. Write the configuration only while the block is idle.
module perspective_slant_scan_generator_unit #(
   parameter int SOURCE_SIZE   = 512,
   parameter int FRACTION_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [pssg_pkg::CFG_INDEX_W-1:0]  csr_index,
   input  logic [pssg_pkg::CFG_W-1:0]        csr_write_data,
   pssg_req_if.sink                          req_ch,
   pssg_rsp_if.source                        rsp_ch
);
   pssg_pkg::cmd_type    cmd;
   pssg_pkg::status_type status;

   pssg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pssg_datapath #(.SOURCE_SIZE(SOURCE_SIZE), .FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .scroll_x         (req_ch.scroll_x),
      .scroll_y         (req_ch.scroll_y),
      .cmd              (cmd),
      .status           (status),
      .source_row       (rsp_ch.source_row),
      .source_col_left  (rsp_ch.source_col_left),
      .source_col_right (rsp_ch.source_col_right),
      .dest_row         (rsp_ch.dest_row),
      .dest_col_left    (rsp_ch.dest_col_left),
      .dest_col_right   (rsp_ch.dest_col_right),
      .end_of_line      (rsp_ch.end_of_line),
      .end_of_frame     (rsp_ch.end_of_frame)
   );

endmodule

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned HALF_PT = (64'd1 << 19) - 1;
   localparam longint unsigned YMASK   = (64'd512 << 36) - 1;
   localparam longint unsigned XMASK   = 64'hffff_ffff;
   localparam int              LIMIT   = 4000000;
   localparam int              SETTLE  = 300;

   typedef struct {
      logic            func;
      logic [8:0]      sx;
      logic [8:0]      sy;
   } scan_cmd_type;

   typedef struct packed {
      logic [8:0] src_row;
      logic [8:0] src_left;
      logic [8:0] src_right;
      logic [8:0] dst_row;
      logic [8:0] dst_left;
      logic [8:0] dst_right;
      logic       eol;
      logic       eof;
   } pair_addr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_write_enable = 1'b0;
   logic [pssg_pkg::CFG_INDEX_W-1:0] csr_index = '0;
   logic [pssg_pkg::CFG_W-1:0]       csr_write_data = '0;

   pssg_req_if req_ch ();
   pssg_rsp_if rsp_ch ();

   perspective_slant_scan_generator_unit DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of registers and scan state
   longint unsigned span_r, sw_r, ew_r, vw_r, vh_r;
   longint unsigned xc, rorg, line_i, pair_i, pair_last;
   longint unsigned xacc, xstep, yacc, cur_row;
   bit              frame_on;

   scan_cmd_type  cmd_q[$];
   pair_addr_type pair_q[$];
   int         errors = 0;
   int         send_idle = 0;   // percent
   int         recv_idle = 0;
   bit         hold_req = 1'b0;
   int         hold_cnt = 0;
   int         cycles = 0;

   // per-line width, half span and source step
   function automatic void start_line();
      longint unsigned vh, w, xend, a, n, q1, r, stp;
      longint          num, diff;
      vh = (vh_r != 0) ? vh_r : 1;
      diff = longint'(ew_r) - longint'(sw_r);
      num = longint'(sw_r) * longint'(vh) * 65536 + diff * longint'(line_i) * 65536;
      cur_row = (rorg + (yacc >> 36)) & 511;
      w = (num <= 0) ? 1 : longint'(num) / longint'(vh);
      if (w == 0) w = 1;
      xend = w >> 16;
      if (xend > vw_r) xend = vw_r;
      xend = xend >> 1;
      pair_last = ((xend != 0) ? xend : 1) - 1;
      pair_i = 0;
      a = (span_r != 0) ? span_r - 1 : 0;
      n = a << 36;
      q1 = n / w;
      r = n % w;
      if (q1 > (YMASK >> 16)) begin
         stp = YMASK;
      end else begin
         stp = (q1 << 16) + ((r << 16) / w);
         if (stp > YMASK) stp = YMASK;
      end
      xstep = stp >> 16;
      if (xstep > XMASK) xstep = XMASK;
      yacc = (yacc + stp) & YMASK;
      xacc = HALF_PT;
   endfunction

   // expected pair for one accepted transaction, if any
   function automatic void predict_pair(scan_cmd_type c);
      longint unsigned vh, half;
      pair_addr_type p;
      if (c.func == pssg_pkg::FUNC_START) begin
         xc = ((longint'(c.sx) + (span_r >> 1)) & 511) << 20;
         rorg = c.sy;
         yacc = HALF_PT << 16;
         line_i = 0;
         frame_on = 1'b1;
         start_line();
         return;
      end
      if (!frame_on) return;
      vh = (vh_r != 0) ? vh_r : 1;
      half = vw_r >> 1;
      p.eol = (pair_i == pair_last);
      p.eof = p.eol && (line_i + 1 >= vh);
      p.src_row   = cur_row[8:0];
      p.src_left  = 9'((xc - xacc) >> 20);
      p.src_right = 9'((xc + xacc) >> 20);
      p.dst_row   = line_i[8:0];
      p.dst_left  = 9'(half - pair_i - 1);
      p.dst_right = 9'(half + pair_i);
      pair_q.push_back(p);
      xacc = (xacc + xstep) & XMASK;
      if (p.eof) begin
         frame_on = 1'b0;
      end else if (p.eol) begin
         line_i = (line_i + 1) & 10'h3ff;
         start_line();
      end else begin
         pair_i = (pair_i + 1) & 9'h1ff;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      scan_cmd_type c;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.func <= pssg_pkg::FUNC_STEP;
         req_ch.scroll_x <= '0;
         req_ch.scroll_y <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            c.func = req_ch.func;
            c.sx = req_ch.scroll_x;
            c.sy = req_ch.scroll_y;
            predict_pair(c);
         end
         if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle) begin
            c = cmd_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.func <= c.func;
            req_ch.scroll_x <= c.sx;
            req_ch.scroll_y <= c.sy;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response monitor and ready control
   always @(posedge clock) begin
      pair_addr_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.source_row, rsp_ch.source_col_left, rsp_ch.source_col_right,
                   rsp_ch.dest_row, rsp_ch.dest_col_left, rsp_ch.dest_col_right,
                   rsp_ch.end_of_line, rsp_ch.end_of_frame};
            if (pair_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction, expected none, got %p", $realtime, got);
            end else begin
               want = pair_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch, expected %p, got %p", $realtime, want, got);
               end
            end
         end
         // long hold-off so the block backs up into its input
         if (hold_req && hold_cnt < 400) begin
            hold_cnt++;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(logic [pssg_pkg::CFG_INDEX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[pssg_pkg::CFG_W-1:0];
      case (idx)
         pssg_pkg::REG_SOURCE_SPAN: span_r = val & 10'h3ff;
         pssg_pkg::REG_START_WIDTH: sw_r = val & 10'h3ff;
         pssg_pkg::REG_END_WIDTH:   ew_r = val & 10'h3ff;
         pssg_pkg::REG_VIEW_WIDTH:  vw_r = val & 10'h3ff;
         pssg_pkg::REG_VIEW_HEIGHT: vh_r = val & 10'h3ff;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_regs(int unsigned sp, int unsigned sw, int unsigned ew,
                           int unsigned vw, int unsigned vh);
      write_reg(pssg_pkg::REG_SOURCE_SPAN, sp);
      write_reg(pssg_pkg::REG_START_WIDTH, sw);
      write_reg(pssg_pkg::REG_END_WIDTH, ew);
      write_reg(pssg_pkg::REG_VIEW_WIDTH, vw);
      write_reg(pssg_pkg::REG_VIEW_HEIGHT, vh);
   endtask

   task automatic push_cmd(logic f, int unsigned x, int unsigned y);
      scan_cmd_type c;
      c.func = f;
      c.sx = x[8:0];
      c.sy = y[8:0];
      cmd_q.push_back(c);
   endtask

   // wait until every sent transaction is answered and line setup is over
   task automatic wait_quiet();
      do begin
         @(posedge clock);
      end while (cmd_q.size() > 0 || req_ch.valid || pair_q.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // finish any open frame, then let the block go quiet
   task automatic drain();
      do begin
         if (cmd_q.size() < 4 && frame_on) push_cmd(pssg_pkg::FUNC_STEP, 0, 0);
         @(posedge clock);
      end while (cmd_q.size() > 0 || req_ch.valid || frame_on || pair_q.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // frames of random scroll with runs of steps
   task automatic random_frames(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) == 0) begin
            push_cmd(pssg_pkg::FUNC_STEP, $urandom, $urandom);   // noise
         end else begin
            push_cmd(pssg_pkg::FUNC_START, $urandom_range(511), $urandom_range(511));
            repeat ($urandom_range(60, 1)) begin
               push_cmd(pssg_pkg::FUNC_STEP, $urandom, $urandom);
               n++;
            end
         end
         n++;
      end
   endtask

   initial begin
      int ph;
      span_r = 512; sw_r = 96; ew_r = 480; vw_r = 256; vh_r = 224;
      xc = 0; rorg = 0; line_i = 0; pair_i = 0; pair_last = 0;
      xacc = HALF_PT; xstep = 0; yacc = HALF_PT << 16; cur_row = 0;
      frame_on = 1'b0;
      send_idle = 13; recv_idle = 74;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle step, scroll extremes, restart mid-frame
      push_cmd(pssg_pkg::FUNC_STEP, 5, 5);
      push_cmd(pssg_pkg::FUNC_START, 0, 0);
      repeat (4) push_cmd(pssg_pkg::FUNC_STEP, 0, 0);
      push_cmd(pssg_pkg::FUNC_START, 511, 511);
      repeat (3) push_cmd(pssg_pkg::FUNC_STEP, 511, 511);
      push_cmd(pssg_pkg::FUNC_START, 256, 1);
      // shrink the height while the frame waits, so it ends after this line
      wait_quiet();
      write_reg(pssg_pkg::REG_VIEW_HEIGHT, 1);
      drain();

      // extremes: narrow lines, wide lines, zero span, zero width and height
      set_regs(2, 1, 1023, 2, 1);
      push_cmd(pssg_pkg::FUNC_START, 170, 85);
      repeat (3) push_cmd(pssg_pkg::FUNC_STEP, 0, 0);
      drain();
      set_regs(512, 1023, 1, 64, 3);
      push_cmd(pssg_pkg::FUNC_START, 85, 170);
      drain();
      set_regs(0, 0, 0, 10, 0);
      push_cmd(pssg_pkg::FUNC_START, 1, 510);
      drain();
      set_regs(1023, 100, 100, 1023, 2);
      push_cmd(pssg_pkg::FUNC_START, 300, 200);
      hold_req = 1'b1;
      drain();

      // random settings, mostly short frames
      for (ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin send_idle = 74; recv_idle = 13; end
         if (ph == 6) begin send_idle = 0; recv_idle = 0; end
         set_regs($urandom_range(512, 2), $urandom_range(1023, 1), $urandom_range(1023, 1),
                  $urandom_range(32, 2), $urandom_range(8, 1));
         random_frames(50);
         drain();
      end

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
